// File: rtl/sha256_stream_hasher_assert.svh
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;
    localparam int COUNT_BITS_DEF = 61;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;
endpackage

// File: rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// one byte per beat; every 64th byte starts a 64-round compression,
// one round a cycle in the shared round unit (not ready meanwhile)
// finishing beat: one or two padded compressions, then eight digest beats
// sustained byte rate set by the round unit
// rst_n asynchronous active low: initial hash values, empty buffer, zero count
module sha256_stream_hasher #(
    parameter int COUNT_BITS = sha_pkg::COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] data_byte,
    input  logic has_byte,
    input  logic last_item,
    output logic out_valid,
    input  logic out_ready,
    output logic [31:0] digest_word,
    output logic [2:0] word_index,
    output logic last_word
);
    typedef enum logic [2:0] {S_IDLE, S_RUN, S_WAIT, S_PAD, S_EMIT} state_t;
    state_t state_reg;
    // byte 0 of the block sits in the top byte
    logic [511:0] blk_reg;
    logic [6:0] fill_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [255:0] hash_reg;
    logic fin_reg, second_reg;
    logic [2:0] idx_reg;
    logic start_reg;
    logic [255:0] hash_out;
    sha_pkg::core_ctl_t ctl;
    logic [63:0] bits;
    logic [255:0] init_h;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            init_h[255 - 32*j -: 32] = sha_pkg::INIT_H[j];
        bits = 64'(total_reg) << 3;
    end

    sha_round_core u_core (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .block(blk_reg),
        .hash_in(hash_reg), .hash_out(hash_out), .ctl(ctl)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign digest_word = hash_reg[255 - 32*idx_reg -: 32];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            total_reg  <= '0;
            hash_reg   <= init_h;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
            start_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fin_reg <= last_item;
                        if (has_byte)
                        begin
                            blk_reg[511 - {fill_reg[5:0], 3'b000} -: 8] <= data_byte;
                            total_reg <= total_reg + COUNT_BITS'(1);
                            if (fill_reg == 7'd63)
                            begin
                                fill_reg  <= '0;
                                start_reg <= 1'b1;
                                state_reg <= S_RUN;
                            end
                            else
                            begin
                                fill_reg <= fill_reg + 7'd1;
                                if (last_item)
                                    state_reg <= S_PAD;
                            end
                        end
                        else if (last_item)
                            state_reg <= S_PAD;
                    end
                end
                S_RUN:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (ctl.done)
                    begin
                        hash_reg <= hash_out;
                        if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            idx_reg    <= '0;
                            state_reg  <= S_EMIT;
                        end
                        else if (fin_reg)
                            state_reg <= S_PAD;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_PAD:
                begin
                    // fill_reg holds the pad position, or 64 for a length-only block
                    for (int i = 0; i < 56; i++)
                    begin
                        if (7'(i) == fill_reg)
                            blk_reg[511 - 8*i -: 8] <= sha_pkg::PAD_BYTE;
                        else if (7'(i) > fill_reg || fill_reg == 7'd64)
                            blk_reg[511 - 8*i -: 8] <= 8'h00;
                    end
                    for (int k = 0; k < 8; k++)
                    begin
                        if (fill_reg < 7'd56 || fill_reg == 7'd64)
                            blk_reg[63 - 8*k -: 8] <= bits[63 - 8*k -: 8];
                        else if (7'(56 + k) == fill_reg)
                            blk_reg[63 - 8*k -: 8] <= sha_pkg::PAD_BYTE;
                        else if (7'(56 + k) > fill_reg)
                            blk_reg[63 - 8*k -: 8] <= 8'h00;
                    end
                    if (fill_reg < 7'd56 || fill_reg == 7'd64)
                    begin
                        second_reg <= 1'b1;
                        fin_reg    <= 1'b0;
                        fill_reg   <= '0;
                    end
                    else
                        fill_reg <= 7'd64;
                    start_reg <= 1'b1;
                    state_reg <= S_RUN;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            hash_reg  <= init_h;
                            total_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`include "sha256_stream_hasher_assert.svh"
    `SHA_ASSERT_IMP(a_no_ready_busy, clk, rst_n, ctl.busy, !in_ready, "ready while compressing")
    `SHA_ASSERT_IMP(a_no_out_busy, clk, rst_n, out_valid, !ctl.busy, "digest during rounds")
    `SHA_ASSERT_NXT(a_start_busy, clk, rst_n, start_reg, ctl.busy, "round unit did not start")
endmodule

// File: rtl/sha_round_core.sv
`timescale 1ns / 1ps
module sha_round_core (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [511:0] block,
    input  logic [255:0] hash_in,
    output logic [255:0] hash_out,
    output sha_pkg::core_ctl_t ctl
);
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0] rnd_reg;
    logic busy_reg, done_reg;
    logic [31:0] wt, s0, s1, t1, t2, e, a, w2, w15;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // window shifts: w_reg[0] is w[t]
    always_comb
    begin
        w2  = w_reg[14];
        w15 = w_reg[1];
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wt  = w_reg[0];
        a   = v_reg[0];
        e   = v_reg[4];
        t1  = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::ROUND_K[rnd_reg] + wt;
        t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32*i -: 32];
            for (int j = 0; j < 8; j++)
                v_reg[j] <= hash_in[255 - 32*j -: 32];
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= s1 + w_reg[9] + s0 + w_reg[0];
            for (int j = 1; j < 8; j++)
            begin
                if (j != 4)
                    v_reg[j] <= v_reg[j-1];
            end
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            hash_out[255 - 32*j -: 32] = hash_in[255 - 32*j -: 32] + v_reg[j];
        ctl.start = start;
        ctl.busy  = busy_reg;
        ctl.done  = done_reg;
    end
endmodule
